@@ rtl/tdor_pkg.sv @@
package tdor_pkg;

  // payload field widths
  localparam int DEST_W   = 22;
  localparam int PORT_W   = 6;
  localparam int VC_W     = 4;
  localparam int DIM_W    = 2;
  localparam int LINK_W   = 4;

  // configuration register widths
  localparam int SIZES_W    = 18;
  localparam int WIDTHS_W   = 12;
  localparam int RIDX_W     = 18;
  localparam int LPORTS_W   = 5;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  // internal widths
  localparam int COORD_W = DEST_W;      // router id / coordinate
  localparam int DIST_W  = COORD_W + 2; // signed ring distance
  localparam int START_W = 8;           // port numbering before wrap

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_DIMS_DEFAULT        = 3;
  localparam int DIM_SIZE_BITS_DEFAULT   = 6;
  localparam int MAX_LOCAL_PORTS_DEFAULT = 16;

  localparam logic [SIZES_W-1:0]  DIM_SIZES_RST    = 18'd16644;
  localparam logic [WIDTHS_W-1:0] DIM_WIDTHS_RST   = 12'd273;
  localparam logic [RIDX_W-1:0]   ROUTER_INDEX_RST = 18'd0;
  localparam logic [LPORTS_W-1:0] LOCAL_PORTS_RST  = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_SIZES    = 2'd0,
    CFG_DIM_WIDTHS   = 2'd1,
    CFG_ROUTER_INDEX = 2'd2,
    CFG_LOCAL_PORTS  = 2'd3
  } cfg_reg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                     is_local;
    logic                     found;
    logic [PORT_W-1:0]        local_port;
    logic [PORT_W-1:0]        base;
    logic [LINK_W-1:0]        link_w;
    logic signed [DIST_W-1:0] ring_dist;
    logic [VC_W-1:0]          vc;
    logic [DIM_W-1:0]         rdim;
  } route_cls_t;

endpackage

@@ rtl/tdor_div.sv @@
module tdor_div #(
  parameter int DW = 22,
  parameter int VW = 5,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem,
  output logic [SW-1:0] side_out
);

  // one quotient bit per stage, restoring
  logic          vld [1:DW];
  logic [VW-1:0] r   [1:DW];
  logic [DW-1:0] dq  [1:DW];
  logic [VW-1:0] dv  [1:DW];
  logic [SW-1:0] sd  [1:DW];

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic          cv;
    logic [VW-1:0] cr;
    logic [DW-1:0] cdq;
    logic [VW-1:0] cdv;
    logic [SW-1:0] csd;
    logic [VW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign cv  = in_valid;
      assign cr  = '0;
      assign cdq = dividend;
      assign cdv = divisor;
      assign csd = side_in;
    end else begin : g_next
      assign cv  = vld[s];
      assign cr  = r[s];
      assign cdq = dq[s];
      assign cdv = dv[s];
      assign csd = sd[s];
    end

    assign trial = {cr, cdq[DW-1]};
    assign ge    = trial >= {1'b0, cdv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= ge ? VW'(trial - {1'b0, cdv}) : trial[VW-1:0];
        dq[s+1] <= {cdq[DW-2:0], ge};
        dv[s+1] <= cdv;
        sd[s+1] <= csd;
      end
    end
  end

  assign out_valid = vld[DW];
  assign quot      = dq[DW];
  assign rem       = r[DW];
  assign side_out  = sd[DW];

endmodule

@@ rtl/tdor_front.sv @@
module tdor_front #(
  parameter int NUM_DIMS        = 3,
  parameter int DIM_SIZE_BITS   = 6,
  parameter int MAX_LOCAL_PORTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tdor_pkg::DEST_W-1:0]   dest_endpoint,
  input  logic [tdor_pkg::PORT_W-1:0]   in_port,
  input  logic [tdor_pkg::VC_W-1:0]     in_vc,
  input  logic [tdor_pkg::DIM_W-1:0]    in_routing_dim,
  input  logic [tdor_pkg::SIZES_W-1:0]  dim_sizes,
  input  logic [tdor_pkg::WIDTHS_W-1:0] dim_widths,
  input  logic [tdor_pkg::RIDX_W-1:0]   router_index,
  input  logic [tdor_pkg::LPORTS_W-1:0] lport_count,
  output logic                          cls_valid,
  input  logic                          cls_ready,
  output tdor_pkg::route_cls_t          cls
);
  import tdor_pkg::*;

  localparam int LPW      = $clog2(MAX_LOCAL_PORTS + 1);
  localparam int SBW      = DIM_SIZE_BITS;
  localparam int PW       = COORD_W + 1;
  localparam int SIDE0_W  = PORT_W + VC_W + DIM_W + RIDX_W;
  localparam int SZ_EXT_W = NUM_DIMS * SBW + SIZES_W;
  localparam int WD_EXT_W = NUM_DIMS * LINK_W + WIDTHS_W;
  localparam int DIX_W    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam logic [PW+SBW-1:0] PROD_LIM = (PW + SBW)'(1) << COORD_W;

  typedef struct packed {
    logic [NUM_DIMS-1:0][COORD_W-1:0] here;
    logic [NUM_DIMS-1:0][COORD_W-1:0] there;
    logic [COORD_W-1:0]               id_h;
    logic [COORD_W-1:0]               id_t;
    logic                             hit;
    logic [PORT_W-1:0]                lport;
    logic [PORT_W-1:0]                port;
    logic [VC_W-1:0]                  vc;
    logic [DIM_W-1:0]                 rdim;
  } rec_t;

  // products above the id range are clamped; quotient is 0 either way
  function automatic logic [PW-1:0] sat_mul(logic [PW-1:0] a, logic [SBW-1:0] b);
    logic [PW+SBW-1:0] p;
    p = {{SBW{1'b0}}, a} * {{PW{1'b0}}, b};
    if (p >= PROD_LIM) begin
      return PROD_LIM[PW-1:0];
    end
    return p[PW-1:0];
  endfunction

  logic                en;
  logic [LPW-1:0]      lp_eff;
  logic [SZ_EXT_W-1:0] sizes_ext;
  logic [WD_EXT_W-1:0] widths_ext;
  logic [SBW-1:0]      dsize  [NUM_DIMS];
  logic [LINK_W-1:0]   dwidth [NUM_DIMS];
  logic [START_W-1:0]  dstart [NUM_DIMS];
  logic [START_W-1:0]  local_start;
  logic [PW-1:0]       prod   [NUM_DIMS];

  assign en       = !cls_valid || cls_ready;
  assign in_ready = en;

  assign sizes_ext  = SZ_EXT_W'(dim_sizes);
  assign widths_ext = WD_EXT_W'(dim_widths);

  always_comb begin
    logic [START_W-1:0] acc;
    acc = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      dsize[d]  = sizes_ext[d*SBW +: SBW];
      dwidth[d] = widths_ext[d*LINK_W +: LINK_W];
      dstart[d] = acc;
      acc       = acc + START_W'({dwidth[d], 1'b0});
    end
    local_start = acc;
  end

  always_comb begin
    if (lport_count == '0) begin
      lp_eff = LPW'(1);
    end else if (32'(lport_count) > MAX_LOCAL_PORTS) begin
      lp_eff = LPW'(MAX_LOCAL_PORTS);
    end else begin
      lp_eff = LPW'(lport_count);
    end
  end

  // prefix products of ring sizes, each registered from the one below it
  always_ff @(posedge clk) begin
    prod[0] <= PW'(1);
    for (int i = 1; i < NUM_DIMS; i++) begin
      prod[i] <= sat_mul(prod[i-1], dsize[i-1]);
    end
  end

  // destination router and local port
  logic                v0;
  logic [DEST_W-1:0]   q0;
  logic [LPW-1:0]      r0;
  logic [SIDE0_W-1:0]  s0;
  logic [RIDX_W-1:0]   s0_rid;
  rec_t                first;
  rec_t                lvl   [NUM_DIMS];
  logic                lvl_v [NUM_DIMS];

  tdor_div #(.DW(DEST_W), .VW(LPW), .SW(SIDE0_W)) u_div_ep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  (dest_endpoint),
    .divisor   (lp_eff),
    .side_in   ({in_port, in_vc, in_routing_dim, router_index}),
    .out_valid (v0),
    .quot      (q0),
    .rem       (r0),
    .side_out  (s0)
  );

  assign s0_rid = s0[RIDX_W-1:0];

  always_comb begin
    first       = '0;
    first.id_t  = q0;
    first.id_h  = COORD_W'(s0_rid);
    first.hit   = q0 == COORD_W'(s0_rid);
    first.lport = PORT_W'(local_start + START_W'(r0));
    first.rdim  = s0[RIDX_W +: DIM_W];
    first.vc    = s0[RIDX_W+DIM_W +: VC_W];
    first.port  = s0[RIDX_W+DIM_W+VC_W +: PORT_W];
  end

  assign lvl[0]   = first;
  assign lvl_v[0] = v0;

  // coordinates, top dimension first
  for (genvar g = 0; g < NUM_DIMS - 1; g++) begin : g_coord
    localparam int DI = NUM_DIMS - 1 - g;
    logic               va;
    logic [COORD_W-1:0] qa, qb;
    logic [PW-1:0]      ra, rb;
    rec_t               sa, nx;

    tdor_div #(.DW(COORD_W), .VW(PW), .SW($bits(rec_t))) u_div_there (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lvl_v[g]),
      .dividend  (lvl[g].id_t),
      .divisor   (prod[DI]),
      .side_in   (lvl[g]),
      .out_valid (va),
      .quot      (qa),
      .rem       (ra),
      .side_out  (sa)
    );

    tdor_div #(.DW(COORD_W), .VW(PW), .SW(1)) u_div_here (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lvl_v[g]),
      .dividend  (lvl[g].id_h),
      .divisor   (prod[DI]),
      .side_in   (1'b0),
      .out_valid (),
      .quot      (qb),
      .rem       (rb),
      .side_out  ()
    );

    always_comb begin
      nx = sa;
      if (prod[DI] == '0) begin
        nx.there[DI] = '0;
        nx.here[DI]  = '0;
      end else begin
        nx.there[DI] = qa;
        nx.id_t      = ra[COORD_W-1:0];
        nx.here[DI]  = qb;
        nx.id_h      = rb[COORD_W-1:0];
      end
    end

    assign lvl[g+1]   = nx;
    assign lvl_v[g+1] = va;
  end

  rec_t fin;
  logic fin_v;
  assign fin   = lvl[NUM_DIMS-1];
  assign fin_v = lvl_v[NUM_DIMS-1];

  logic                     d_differ [NUM_DIMS];
  logic                     d_pos    [NUM_DIMS];
  logic                     d_hzero  [NUM_DIMS];
  logic signed [DIST_W-1:0] d_dist   [NUM_DIMS];

  always_comb begin
    logic [COORD_W-1:0]       h, t;
    logic signed [DIST_W-1:0] dp, dn, sz;
    for (int d = 0; d < NUM_DIMS; d++) begin
      h  = (d == 0) ? fin.id_h : fin.here[d];
      t  = (d == 0) ? fin.id_t : fin.there[d];
      sz = DIST_W'(dsize[d]);
      dn = DIST_W'(h) - DIST_W'(t);
      if (dn < 0) begin
        dn = dn + sz;
      end
      dp = DIST_W'(t) - DIST_W'(h);
      if (dp < 0) begin
        dp = dp + sz;
      end
      d_differ[d] = h != t;
      d_hzero[d]  = h == '0;
      d_pos[d]    = dp <= dn;
      d_dist[d]   = d_pos[d] ? dp : dn;
    end
  end

  logic             found, skip;
  logic [DIM_W-1:0] ndim;
  logic [DIX_W-1:0] dsel;
  route_cls_t       cls_next;

  always_comb begin
    found = 1'b0;
    skip  = 1'b0;
    ndim  = fin.rdim;
    dsel  = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (!found && d >= int'(fin.rdim)) begin
        if (d_differ[d]) begin
          found = 1'b1;
          dsel  = DIX_W'(d);
        end else begin
          skip = 1'b1;
          ndim = ndim + DIM_W'(1);
        end
      end
    end
  end

  always_comb begin
    cls_next            = '0;
    cls_next.is_local   = fin.hit;
    cls_next.found      = found;
    cls_next.local_port = fin.lport;
    cls_next.base       = PORT_W'(dstart[dsel] +
                          (d_pos[dsel] ? START_W'(0) : START_W'(dwidth[dsel])));
    cls_next.link_w     = dwidth[dsel];
    cls_next.ring_dist  = d_dist[dsel];
    cls_next.rdim       = fin.hit ? fin.rdim : ndim;
    // dateline: leaving coordinate 0 from a network port
    if (fin.hit) begin
      cls_next.vc = fin.vc;
    end else if (found && d_hzero[dsel] && START_W'(fin.port) < local_start) begin
      cls_next.vc = fin.vc ^ VC_W'(1);
    end else if (skip) begin
      cls_next.vc = fin.vc & ~VC_W'(1);
    end else begin
      cls_next.vc = fin.vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (en) begin
      cls_valid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls <= cls_next;
    end
  end

endmodule

@@ rtl/tdor_fifo.sv @@
module tdor_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign in_ready  = cnt != (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr <= (32'(wr) == DEPTH - 1) ? '0 : wr + AW'(1);
      end
      if (pop) begin
        rd <= (32'(rd) == DEPTH - 1) ? '0 : rd + AW'(1);
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= in_data;
    end
  end

endmodule

@@ rtl/tdor_back.sv @@
module tdor_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tdor_pkg::route_cls_t        cls,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tdor_pkg::PORT_W-1:0] route_port,
  output logic [tdor_pkg::VC_W-1:0]   new_vc,
  output logic [tdor_pkg::DIM_W-1:0]  new_routing_dim
);
  import tdor_pkg::*;

  localparam int MAG_W = DIST_W - 1;

  logic               en;
  logic [MAG_W-1:0]   mag;
  logic               dv;
  logic [LINK_W-1:0]  rm;
  route_cls_t         c;
  logic [LINK_W-1:0]  lane;
  logic [PORT_W-1:0]  port_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign mag = cls.ring_dist[DIST_W-1] ? MAG_W'(-cls.ring_dist)
                                       : cls.ring_dist[MAG_W-1:0];

  // lane = distance mod link count
  tdor_div #(.DW(MAG_W), .VW(LINK_W), .SW($bits(route_cls_t))) u_div_lane (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  (mag),
    .divisor   (cls.link_w),
    .side_in   (cls),
    .out_valid (dv),
    .quot      (),
    .rem       (rm),
    .side_out  (c)
  );

  always_comb begin
    if (c.link_w > LINK_W'(1)) begin
      if (c.ring_dist[DIST_W-1] && rm != '0) begin
        lane = c.link_w - rm;
      end else begin
        lane = rm;
      end
    end else begin
      lane = '0;
    end
  end

  always_comb begin
    priority if (c.is_local) begin
      port_next = c.local_port;
    end else if (c.found) begin
      port_next = c.base + PORT_W'(lane);
    end else begin
      port_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      route_port      <= port_next;
      new_vc          <= c.vc;
      new_routing_dim <= c.rdim;
    end
  end

endmodule

@@ rtl/torus_dimension_order_route.sv @@
// Torus dimension-order route computation. Each request carries a packet
// header; the result gives the output port, the virtual channel and the
// routing dimension to carry on. One request is taken per clock and results
// leave in order, one per clock, as long as the output is not stalled.
// The front runs a bit-serial pipelined divider for the destination router
// (22 stages) and one per coordinate above the lowest (22 stages each), plus
// a classify register; a 4-entry queue follows, then a 23-stage divider for
// the lane and the output register. After a write to dim_sizes the derived
// size products settle through a chain of registers, well under the pipeline
// depth.
module torus_dimension_order_route #(
  parameter int NUM_DIMS        = tdor_pkg::NUM_DIMS_DEFAULT,
  parameter int DIM_SIZE_BITS   = tdor_pkg::DIM_SIZE_BITS_DEFAULT,
  parameter int MAX_LOCAL_PORTS = tdor_pkg::MAX_LOCAL_PORTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dest_endpoint, in_port, in_vc, in_routing_dim, zero pad
  input  logic [tdor_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // output port, new_vc, new_routing_dim, zero pad
  output logic [tdor_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [tdor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdor_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tdor_pkg::*;

  logic [SIZES_W-1:0]  dim_sizes;
  logic [WIDTHS_W-1:0] dim_widths;
  logic [RIDX_W-1:0]   router_index;
  logic [LPORTS_W-1:0] lport_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_sizes    <= DIM_SIZES_RST;
      dim_widths   <= DIM_WIDTHS_RST;
      router_index <= ROUTER_INDEX_RST;
      lport_count  <= LOCAL_PORTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIM_SIZES:    dim_sizes    <= cfg_data[SIZES_W-1:0];
        CFG_DIM_WIDTHS:   dim_widths   <= cfg_data[WIDTHS_W-1:0];
        CFG_ROUTER_INDEX: router_index <= cfg_data[RIDX_W-1:0];
        CFG_LOCAL_PORTS:  lport_count  <= cfg_data[LPORTS_W-1:0];
      endcase
    end
  end

  logic                         cls_valid, cls_ready;
  route_cls_t                   cls;
  logic                         q_valid, q_ready;
  logic [$bits(route_cls_t)-1:0] q_data;
  logic [PORT_W-1:0]            route_port;
  logic [VC_W-1:0]              new_vc;
  logic [DIM_W-1:0]             new_routing_dim;

  tdor_front #(
    .NUM_DIMS        (NUM_DIMS),
    .DIM_SIZE_BITS   (DIM_SIZE_BITS),
    .MAX_LOCAL_PORTS (MAX_LOCAL_PORTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .dest_endpoint  (s_axis_tdata[DEST_W-1:0]),
    .in_port        (s_axis_tdata[DEST_W +: PORT_W]),
    .in_vc          (s_axis_tdata[DEST_W+PORT_W +: VC_W]),
    .in_routing_dim (s_axis_tdata[DEST_W+PORT_W+VC_W +: DIM_W]),
    .dim_sizes      (dim_sizes),
    .dim_widths     (dim_widths),
    .router_index   (router_index),
    .lport_count    (lport_count),
    .cls_valid      (cls_valid),
    .cls_ready      (cls_ready),
    .cls            (cls)
  );

  tdor_fifo #(.W($bits(route_cls_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_data   (cls),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  tdor_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (q_valid),
    .in_ready        (q_ready),
    .cls             (q_data),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .route_port      (route_port),
    .new_vc          (new_vc),
    .new_routing_dim (new_routing_dim)
  );

  assign m_axis_tdata = {(OUT_DATA_W - PORT_W - VC_W - DIM_W)'(0),
                         new_routing_dim, new_vc, route_port};

endmodule

@@ rtl/tdor_checker.sv @@
module tdor_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tdor_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tdor_pkg::*;

  // nothing comes out right after reset: the pipeline is empty
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // the front takes requests as soon as reset is released
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_axis_tready)
    else $error("not ready after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:PORT_W+VC_W+DIM_W] == '0)
    else $error("result pad bits not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind torus_dimension_order_route tdor_checker u_tdor_checker (.*);
